>>> hdl/sbge_pkg.sv
// Shared types and constants of the seven-bit group encoder.
// Used by the interfaces, the controller, the datapath and the top level.
package sbge_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CODE_W      = 7;
    localparam int unsigned STORE_DEPTH = 7;
    localparam int unsigned IDX_W       = 3;

    localparam logic [BYTE_W-1:0] LOW_MASK = 8'h7f;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // store the request now on the input channel
        logic load;     // move the next group byte into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic closes;      // the request on the input channel completes a group
        logic slot_free;   // the output register can take a new byte this cycle
        logic final_item;  // the next byte to load is the last of the group
    } status_t;

endpackage

>>> hdl/sbge_if.sv
// Handshake channels of the seven-bit group encoder: raw input bytes and coded output bytes.
// Depends on sbge_pkg for the field widths.
interface sbge_raw_if;
    logic                               valid;
    logic                               ready;
    logic [sbge_pkg::BYTE_W-1:0]        data_byte;
    logic                               message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface sbge_coded_if;
    logic                               valid;
    logic                               ready;
    logic [sbge_pkg::CODE_W-1:0]        coded_byte;
    logic                               group_end;
    logic                               message_done;

    modport source (output valid, output coded_byte, output group_end, output message_done,
                    input ready);
    modport sink   (input valid, input coded_byte, input group_end, input message_done,
                    output ready);
endinterface

>>> hdl/sbge_ctrl.sv
// Controller of the seven-bit group encoder: collects requests, then sequences a group out.
// Depends on sbge_pkg for the state, command and status types.
module sbge_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              raw_valid,
    output logic              raw_ready,
    input  sbge_pkg::status_t status,
    output sbge_pkg::cmd_t    cmd
);

    sbge_pkg::state_t state_reg;
    sbge_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbge_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        raw_ready  = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            sbge_pkg::ST_COLLECT:
            begin
                raw_ready  = 1'b1;
                cmd.accept = raw_valid;
                if (raw_valid && status.closes)
                begin
                    state_next = sbge_pkg::ST_EMIT;
                end
            end
            sbge_pkg::ST_EMIT:
            begin
                cmd.load = status.slot_free;
                if (status.slot_free && status.final_item)
                begin
                    state_next = sbge_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = sbge_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

>>> hdl/sbge_datapath.sv
// Datapath of the seven-bit group encoder: holding store, header, counters and output register.
// Depends on sbge_pkg for widths and the command and status types.
module sbge_datapath #(
    parameter int unsigned GROUP_BYTES = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sbge_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          message_end,
    input  sbge_pkg::cmd_t                cmd,
    output sbge_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sbge_pkg::CODE_W-1:0]   coded_byte,
    output logic                          group_end,
    output logic                          message_done
);

    logic [sbge_pkg::CODE_W-1:0] store_reg [sbge_pkg::STORE_DEPTH];
    logic [sbge_pkg::CODE_W-1:0] header_reg, header_next;
    logic [sbge_pkg::IDX_W-1:0]  count_reg;
    logic [sbge_pkg::IDX_W-1:0]  filled;
    logic [sbge_pkg::IDX_W-1:0]  idx_reg;
    logic [sbge_pkg::IDX_W-1:0]  rd_idx;
    logic                        last_reg;
    logic                        out_valid_reg;
    logic [sbge_pkg::CODE_W-1:0] out_byte_reg;
    logic                        group_end_reg;
    logic                        message_done_reg;
    logic [sbge_pkg::CODE_W-1:0] load_byte;

    // While collecting, the position counter stays below the store depth, so count + 1 fits.
    assign filled = count_reg + 3'd1;

    always_comb
    begin
        header_next = header_reg;
        if (data_byte[sbge_pkg::BYTE_W-1])
        begin
            header_next[count_reg] = 1'b1;
        end
    end

    assign status.closes     = message_end || (filled >= sbge_pkg::IDX_W'(GROUP_BYTES));
    assign status.slot_free  = !out_valid_reg || out_ready;
    assign status.final_item = (idx_reg == count_reg);

    // Entry k of the store is output byte k + 1; byte 0 is the header.
    assign rd_idx    = idx_reg - 3'd1;
    assign load_byte = (idx_reg == '0) ? header_reg : store_reg[rd_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store_reg[count_reg] <= sbge_pkg::CODE_W'(data_byte & sbge_pkg::LOW_MASK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                header_reg <= header_next;
                if (status.closes)
                begin
                    // During emission the counter holds the number of stored bytes.
                    count_reg <= filled;
                    last_reg  <= message_end;
                    idx_reg   <= '0;
                end
                else
                begin
                    count_reg <= filled;
                end
            end
            if (cmd.load)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (status.final_item)
                begin
                    header_reg <= '0;
                    count_reg  <= '0;
                end
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg     <= load_byte;
            group_end_reg    <= status.final_item;
            message_done_reg <= status.final_item && last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coded_byte   = out_byte_reg;
    assign group_end    = group_end_reg;
    assign message_done = message_done_reg;

endmodule

>>> hdl/seven_bit_group_encoder_core.sv
// Seven-bit group encoder: packs 8-bit bytes into groups of a header plus 7-bit bytes.
// The request that closes a group moves the controller to its emit state, which loads
// the header into the output register; the stored bytes follow one per cycle while the
// output side takes them. A group of N requests gives N + 1 output bytes, a header and
// N stored bytes; the controller closes intake while a group drains.
// Reset (rst_n, asynchronous, active low) empties the group and drops any pending output.
module seven_bit_group_encoder_core #(
    parameter int unsigned GROUP_BYTES = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    sbge_raw_if.sink            raw_ch,
    sbge_coded_if.source        coded_ch
);

    // The controller owns the sequencing: it takes requests until one closes a group,
    // then steps the datapath through the header and the stored bytes. The datapath owns
    // all payload storage and reports whether a group closes and whether the output
    // register can take the next byte.
    sbge_pkg::cmd_t    cmd;
    sbge_pkg::status_t status;

    sbge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_ch.valid),
        .raw_ready (raw_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The output register parts the two sides: a new group can start collecting while
    // the last byte of the previous group still waits on the output channel.
    sbge_datapath #(
        .GROUP_BYTES (GROUP_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (raw_ch.data_byte),
        .message_end  (raw_ch.message_end),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (coded_ch.valid),
        .out_ready    (coded_ch.ready),
        .coded_byte   (coded_ch.coded_byte),
        .group_end    (coded_ch.group_end),
        .message_done (coded_ch.message_done)
    );

    // A request that closes a group stops intake until the group is out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (raw_ch.valid && raw_ch.ready && status.closes) |=> !raw_ch.ready)
        else $error("intake stayed open after a group closed");

    // A request that does not close a group leaves intake open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (raw_ch.valid && raw_ch.ready && !status.closes) |=> raw_ch.ready)
        else $error("intake closed without a completed group");

    // The end of a message is only ever marked on the last byte of a group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (coded_ch.valid && coded_ch.message_done) |-> coded_ch.group_end)
        else $error("message end outside a group end");

    // Loading a byte never overwrites one the output side has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && coded_ch.valid) |-> coded_ch.ready)
        else $error("output byte overwritten before it was taken");

endmodule
